// ===== sv/dams_pkg.sv =====
// Package for the driver assist mode supervisor: types, codes and the transition table.
`default_nettype none
package dams_pkg;

  localparam int ModeW = 4;

  // display modes
  localparam logic [ModeW-1:0] MODE_OFF      = 4'd0;
  localparam logic [ModeW-1:0] MODE_AVAIL    = 4'd1;
  localparam logic [ModeW-1:0] MODE_ENG1     = 4'd2;
  localparam logic [ModeW-1:0] MODE_ENG2     = 4'd3;
  localparam logic [ModeW-1:0] MODE_AVAIL_L3 = 4'd4;
  localparam logic [ModeW-1:0] MODE_ENG_L3   = 4'd5;
  localparam logic [ModeW-1:0] MODE_TAKEOVER = 4'd6;
  localparam logic [ModeW-1:0] MODE_MRM      = 4'd7;
  localparam logic [ModeW-1:0] MODE_DEGRADED = 4'd8;
  localparam logic [ModeW-1:0] MODE_FAULT    = 4'd9;
  localparam logic [ModeW-1:0] MODE_COUNT    = 4'd10;

  // operations
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_REQ    = 2'd2;
  localparam logic [1:0] OP_FORCE  = 2'd3;

  localparam logic [31:0] SEQ_WRAP_THRESHOLD = 32'h8000_0000;
  localparam logic [31:0] SEQ_WRAP_LIMIT     = 32'd1000;
  localparam logic [15:0] WINDOW_RESET       = 16'd300;

  typedef struct packed {
    logic [1:0]       operation;
    logic [31:0]      time_ms;
    logic [31:0]      seq_number;
    logic             msg_valid;
    logic             assist_available;
    logic             assist_engaged;
    logic [2:0]       automation_level;
    logic [ModeW-1:0] target_mode;
    logic             force_degraded;
  } in_t;

  typedef struct packed {
    logic             accepted;
    logic [ModeW-1:0] mode;
    logic             transition_blocked;
    logic             stale_detected;
    logic             degraded_shown;
  } out_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [31:0]      last_seq;
    logic [31:0]      last_time;
    logic             stale_rep;
    logic             forced;
  } st_t;

  // bit t of the row for mode f: move f -> t allowed
  function automatic logic move_allowed(input logic [ModeW-1:0] from,
                                        input logic [ModeW-1:0] to);
    logic [15:0] row;
    row = 16'h0000;
    unique case (from)
      MODE_OFF:      row = 16'h0302;
      MODE_AVAIL:    row = 16'h031D;
      MODE_ENG1:     row = 16'h030F;
      MODE_ENG2:     row = 16'h030F;
      MODE_AVAIL_L3: row = 16'h0323;
      MODE_ENG_L3:   row = 16'h03D1;
      MODE_TAKEOVER: row = 16'h02A3;
      MODE_MRM:      row = 16'h0203;
      MODE_DEGRADED: row = 16'h0203;
      MODE_FAULT:    row = 16'h0001;
      default:       row = 16'h0000;
    endcase
    return (to < MODE_COUNT) && row[to];
  endfunction

  function automatic logic [ModeW-1:0] derive_mode(input logic       valid,
                                                   input logic       avail,
                                                   input logic       engaged,
                                                   input logic [2:0] level);
    logic [ModeW-1:0] m;
    m = MODE_OFF;
    if (valid && avail) begin
      if (engaged) begin
        if (level == 3'd1)      m = MODE_ENG1;
        else if (level == 3'd2) m = MODE_ENG2;
        else if (level >= 3'd3 && level <= 3'd5) m = MODE_ENG_L3;
        else                    m = MODE_OFF;
      end else begin
        m = (level >= 3'd3) ? MODE_AVAIL_L3 : MODE_AVAIL;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== sv/dams_core.sv =====
// Event evaluation: next supervisor state and result for one transaction.
`default_nettype none
module dams_core (
  input  wire dams_pkg::in_t  item,
  input  wire dams_pkg::st_t  st,
  input  wire logic [15:0]    window,
  output dams_pkg::st_t       st_nxt,
  output dams_pkg::out_t      res
);
  import dams_pkg::*;

  logic             seq_ok;
  logic [ModeW-1:0] want;
  logic [31:0]      age;
  logic             accepted;
  logic             blocked;
  logic             stale;

  assign seq_ok = (st.last_seq == 32'd0) || (item.seq_number > st.last_seq) ||
                  ((st.last_seq > SEQ_WRAP_THRESHOLD) &&
                   (item.seq_number < SEQ_WRAP_LIMIT));
  assign want = derive_mode(item.msg_valid, item.assist_available,
                            item.assist_engaged, item.automation_level);
  assign age = item.time_ms - st.last_time;

  always_comb begin
    st_nxt   = st;
    accepted = 1'b0;
    blocked  = 1'b0;
    stale    = 1'b0;
    unique case (item.operation)
      OP_UPDATE: begin
        if (seq_ok) begin
          accepted         = 1'b1;
          st_nxt.last_time = item.time_ms;
          st_nxt.last_seq  = item.seq_number;
          st_nxt.stale_rep = 1'b0;
          if (want != st.mode) begin
            if (move_allowed(st.mode, want)) st_nxt.mode = want;
            else                             blocked = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if ((age > {16'd0, window}) && !st.stale_rep) begin
          st_nxt.stale_rep = 1'b1;
          if (st.mode != MODE_OFF && st.mode != MODE_FAULT) begin
            st_nxt.mode = MODE_DEGRADED;
            stale       = 1'b1;
          end
        end
      end
      OP_REQ: begin
        if (move_allowed(st.mode, item.target_mode)) begin
          st_nxt.mode = item.target_mode;
          accepted    = 1'b1;
        end else begin
          blocked = 1'b1;
        end
      end
      OP_FORCE: begin
        if (st.forced != item.force_degraded) begin
          st_nxt.forced = item.force_degraded;
          if (item.force_degraded) st_nxt.mode = MODE_DEGRADED;
        end
      end
      default: ;
    endcase
  end

  assign res.accepted           = accepted;
  assign res.mode               = st_nxt.mode;
  assign res.transition_blocked = blocked;
  assign res.stale_detected     = stale;
  assign res.degraded_shown     = (st_nxt.mode == MODE_DEGRADED) || st_nxt.forced;

endmodule
`default_nettype wire

// ===== sv/driver_assist_mode_supervisor.sv =====
// Top level of the driver assist mode supervisor.
// Usage:
//   Input channel in_valid/in_stall/in_data carries one event per transaction:
//   engagement update, time tick, transition request or forced-degraded set.
//   Output channel out_valid/out_stall/out_data returns exactly one result
//   per event, in order.
//   cfg_we/cfg_wdata write the 16-bit freshness window (ms); write only when
//   no transaction is in flight.
// Timing:
//   Two-stage path: an input register, then the evaluation logic, then the
//   result register, which loads as the event leaves the input register; a
//   held result register can keep the event waiting. Throughput is one event
//   per cycle while out_stall is low; supervisor state updates as an event
//   leaves the input register, so a following event sees it at once.
// Reset (rst_n low, synchronous): mode off, sequence and time zero, flags
//   cleared, window 300 ms, both stages empty.
// Stall: out_stall holds the result register; the input register still
//   fills, and in_stall rises only when both stages hold an event.
`default_nettype none
module driver_assist_mode_supervisor (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire dams_pkg::in_t    in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output dams_pkg::out_t        out_data,
  input  wire                   cfg_we,
  input  wire [15:0]            cfg_wdata
);
  import dams_pkg::*;

  logic        s1_valid_r;
  in_t         s1_data_r;
  logic        out_valid_r;
  out_t        out_data_r;
  st_t         st_r;
  st_t         st_nxt;
  out_t        res;
  logic [15:0] window_r;
  logic        s1_move;
  logic        in_take;

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  dams_core u_core (
    .item   (s1_data_r),
    .st     (st_r),
    .window (window_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      window_r    <= WINDOW_RESET;
    end else begin
      if (cfg_we) window_r <= cfg_wdata;
      if (in_take)      s1_valid_r <= 1'b1;
      else if (s1_move) s1_valid_r <= 1'b0;
      if (s1_move) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_data_r <= in_data;
    if (s1_move) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the driver assist mode supervisor.
`default_nettype none
module testbench;
  import dams_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  driver_assist_mode_supervisor u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // supervisor state as the testbench expects it
  logic [3:0]  mode_now = MODE_OFF;
  logic [31:0] seq_last = '0;
  logic [31:0] time_last = '0;
  logic        stale_flagged = 1'b0;
  logic        forced_flag = 1'b0;
  logic [15:0] window_ms = WINDOW_RESET;

  logic [31:0] clock_ms = '0;
  out_t        pending_results [$];
  int          errors = 0;
  int          ops_seen [4] = '{0, 0, 0, 0};
  int          blocked_seen = 0;
  int          stale_seen = 0;
  bit          steady = 1'b0;
  int          hold_cycles = 0;

  typedef struct {
    in_t  ev;
    bit   typed;
    out_t want;
  } row_t;

  function automatic bit can_move(logic [3:0] from, logic [3:0] to);
    logic [15:0] row;
    case (from)
      MODE_OFF:      row = 16'h0302;
      MODE_AVAIL:    row = 16'h031D;
      MODE_ENG1,
      MODE_ENG2:     row = 16'h030F;
      MODE_AVAIL_L3: row = 16'h0323;
      MODE_ENG_L3:   row = 16'h03D1;
      MODE_TAKEOVER: row = 16'h02A3;
      MODE_MRM,
      MODE_DEGRADED: row = 16'h0203;
      MODE_FAULT:    row = 16'h0001;
      default:       row = 16'h0000;
    endcase
    return to < MODE_COUNT && row[to];
  endfunction

  function automatic logic [3:0] wanted_mode(in_t ev);
    if (!(ev.msg_valid && ev.assist_available)) return MODE_OFF;
    if (!ev.assist_engaged) return (ev.automation_level >= 3'd3) ? MODE_AVAIL_L3 : MODE_AVAIL;
    case (ev.automation_level)
      3'd1:             return MODE_ENG1;
      3'd2:             return MODE_ENG2;
      3'd3, 3'd4, 3'd5: return MODE_ENG_L3;
      default:          return MODE_OFF;
    endcase
  endfunction

  // anti-replay: first update, newer number, or wrap from the top half to a small number
  function automatic bit seq_fresh(logic [31:0] s);
    return seq_last == '0 || s > seq_last ||
           (seq_last > SEQ_WRAP_THRESHOLD && s < SEQ_WRAP_LIMIT);
  endfunction

  function automatic out_t step_supervisor(in_t ev);
    out_t        r;
    logic [3:0]  want;
    logic [31:0] age;
    r = '0;
    case (ev.operation)
      OP_UPDATE: begin
        if (seq_fresh(ev.seq_number)) begin
          want = wanted_mode(ev);
          r.accepted = 1'b1;
          time_last = ev.time_ms;
          seq_last = ev.seq_number;
          stale_flagged = 1'b0;
          if (want != mode_now) begin
            if (can_move(mode_now, want)) mode_now = want;
            else r.transition_blocked = 1'b1;
          end
        end
      end
      OP_TICK: begin
        age = ev.time_ms - time_last;
        if (age > {16'd0, window_ms} && !stale_flagged) begin
          stale_flagged = 1'b1;
          if (mode_now != MODE_OFF && mode_now != MODE_FAULT) begin
            mode_now = MODE_DEGRADED;
            r.stale_detected = 1'b1;
          end
        end
      end
      OP_REQ: begin
        if (can_move(mode_now, ev.target_mode)) begin
          mode_now = ev.target_mode;
          r.accepted = 1'b1;
        end else begin
          r.transition_blocked = 1'b1;
        end
      end
      OP_FORCE: begin
        if (forced_flag != ev.force_degraded) begin
          forced_flag = ev.force_degraded;
          if (ev.force_degraded) mode_now = MODE_DEGRADED;
        end
      end
      default: ;
    endcase
    r.mode = mode_now;
    r.degraded_shown = (mode_now == MODE_DEGRADED) || forced_flag;
    return r;
  endfunction

  function automatic in_t ev_update(logic [31:0] t, logic [31:0] s, bit v, bit a, bit e,
                                    logic [2:0] lvl);
    in_t ev;
    ev = '0;
    ev.operation = OP_UPDATE;
    ev.time_ms = t;
    ev.seq_number = s;
    ev.msg_valid = v;
    ev.assist_available = a;
    ev.assist_engaged = e;
    ev.automation_level = lvl;
    return ev;
  endfunction

  function automatic in_t ev_tick(logic [31:0] t);
    in_t ev;
    ev = '0;
    ev.operation = OP_TICK;
    ev.time_ms = t;
    return ev;
  endfunction

  function automatic in_t ev_request(logic [3:0] target);
    in_t ev;
    ev = '0;
    ev.operation = OP_REQ;
    ev.target_mode = target;
    return ev;
  endfunction

  function automatic in_t ev_force(bit f);
    in_t ev;
    ev = '0;
    ev.operation = OP_FORCE;
    ev.force_degraded = f;
    return ev;
  endfunction

  function automatic out_t outcome(bit acc, logic [3:0] m, bit blk, bit stl, bit shown);
    out_t r;
    r.accepted = acc;
    r.mode = m;
    r.transition_blocked = blk;
    r.stale_detected = stl;
    r.degraded_shown = shown;
    return r;
  endfunction

  // mostly in-order updates on an advancing clock and legal requests, some replays and noise
  function automatic in_t next_event();
    in_t ev;
    int  pick;
    int  t;
    ev = '0;
    pick = $urandom_range(0, 99);
    ev.operation = pick < 40 ? OP_UPDATE : pick < 65 ? OP_TICK : pick < 90 ? OP_REQ : OP_FORCE;
    if ($urandom_range(0, 15) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, 2 * window_ms + 2);
    ev.time_ms = clock_ms;
    pick = $urandom_range(0, 19);
    if (pick == 0) ev.seq_number = $urandom();
    else if (pick == 1) ev.seq_number = $urandom_range(0, 999);
    else if (pick < 4) ev.seq_number = seq_last - $urandom_range(0, 3);
    else ev.seq_number = seq_last + $urandom_range(1, 4);
    ev.msg_valid = $urandom_range(0, 7) != 0;
    ev.assist_available = $urandom_range(0, 7) != 0;
    ev.assist_engaged = 1'($urandom_range(0, 1));
    ev.automation_level = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 2) != 0) begin
      do t = $urandom_range(0, 9); while (!can_move(mode_now, t[3:0]));
      ev.target_mode = t[3:0];
    end else begin
      ev.target_mode = 4'($urandom_range(0, 15));
    end
    ev.force_degraded = $urandom_range(0, 3) == 0;
    return ev;
  endfunction

  task automatic send_event(input in_t ev, input bit typed, input out_t want);
    int   gap;
    out_t predicted;
    gap = steady ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = step_supervisor(ev);
    pending_results.push_back(typed ? want : predicted);
    ops_seen[ev.operation]++;
    if (predicted.transition_blocked) blocked_seen++;
    if (predicted.stale_detected) stale_seen++;
  endtask

  // stop offering and let every transaction come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_window(input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    window_ms = value;
  endtask

  function automatic void field_mismatch(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endfunction

  // result side: random hold-offs, or a long one when asked
  initial begin : result_sink
    int   n;
    out_t want;
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = steady ? 0 : $urandom_range(0, 6);
      end
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1 || out_stall);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.accepted !== want.accepted)
          field_mismatch("accepted", want.accepted, out_data.accepted);
        if (out_data.mode !== want.mode)
          field_mismatch("mode", want.mode, out_data.mode);
        if (out_data.transition_blocked !== want.transition_blocked)
          field_mismatch("transition_blocked", want.transition_blocked,
                         out_data.transition_blocked);
        if (out_data.stale_detected !== want.stale_detected)
          field_mismatch("stale_detected", want.stale_detected, out_data.stale_detected);
        if (out_data.degraded_shown !== want.degraded_shown)
          field_mismatch("degraded_shown", want.degraded_shown, out_data.degraded_shown);
      end
    end
  end

  initial begin : watchdog
    #2_400_000;
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    row_t        opening [$];
    int unsigned window_plan [8] = '{1, 65535, 0, 50, 300, 1000, 7, 0};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    opening.push_back('{ev_tick(0), 1'b1, outcome(0, MODE_OFF, 0, 0, 0)});
    opening.push_back('{ev_request(4'd15), 1'b1, outcome(0, MODE_OFF, 1, 0, 0)});
    opening.push_back('{ev_request(MODE_OFF), 1'b1, outcome(0, MODE_OFF, 1, 0, 0)});
    // off cannot go straight to availL3
    opening.push_back('{ev_update(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0, 7), 1'b1,
                        outcome(1, MODE_OFF, 1, 0, 0)});
    // sequence wraps from the top to a small number
    opening.push_back('{ev_update(100, 5, 1, 1, 0, 0), 1'b1, outcome(1, MODE_AVAIL, 0, 0, 0)});
    opening.push_back('{ev_update(110, 5, 1, 1, 1, 1), 1'b1, outcome(0, MODE_AVAIL, 0, 0, 0)});
    opening.push_back('{ev_update(200, 6, 1, 1, 1, 1), 1'b0, '0});
    opening.push_back('{ev_request(MODE_ENG1), 1'b0, '0});
    opening.push_back('{ev_update(210, 7, 1, 1, 1, 2), 1'b0, '0});
    opening.push_back('{ev_update(220, 8, 1, 1, 1, 5), 1'b1, outcome(1, MODE_ENG2, 1, 0, 0)});
    opening.push_back('{ev_update(230, 9, 1, 1, 1, 6), 1'b0, '0});
    opening.push_back('{ev_update(240, 10, 0, 1, 0, 3), 1'b0, '0});
    opening.push_back('{ev_request(MODE_AVAIL), 1'b0, '0});
    opening.push_back('{ev_request(MODE_AVAIL_L3), 1'b0, '0});
    opening.push_back('{ev_update(1000, 11, 1, 1, 1, 3), 1'b0, '0});
    opening.push_back('{ev_request(MODE_TAKEOVER), 1'b0, '0});
    opening.push_back('{ev_request(MODE_MRM), 1'b0, '0});
    // one past the reset window: stale, drop to degraded
    opening.push_back('{ev_tick(1301), 1'b1, outcome(0, MODE_DEGRADED, 0, 1, 1)});
    opening.push_back('{ev_tick(32'hFFFF_FFFF), 1'b1, outcome(0, MODE_DEGRADED, 0, 0, 1)});
    opening.push_back('{ev_force(1), 1'b0, '0});
    opening.push_back('{ev_request(MODE_AVAIL), 1'b0, '0});
    opening.push_back('{ev_force(1), 1'b0, '0});
    opening.push_back('{ev_force(0), 1'b0, '0});
    opening.push_back('{ev_request(MODE_FAULT), 1'b0, '0});
    opening.push_back('{ev_update(1400, 0, 1, 1, 0, 0), 1'b1, outcome(0, MODE_FAULT, 0, 0, 0)});
    foreach (opening[i]) send_event(opening[i].ev, opening[i].typed, opening[i].want);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_window(16'(p == 4 ? $urandom_range(2, 65534) : window_plan[p]));
      steady = (p == 3 || p == 5);
      // back-pressure: output held long while input keeps coming
      if (p == 3) hold_cycles = 40;
      repeat (206) send_event(next_event(), 1'b0, '0);
      drain();
    end

    $display("covered %0d updates, %0d ticks, %0d requests, %0d forced-degraded commands",
             ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3]);
    $display("%0d refused moves, %0d stale drops, windows 0 to 65535", blocked_seen,
             stale_seen);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
`default_nettype wire
